// ===== hdl/athc_pkg.sv =====
package athc_pkg;

    // sizes of the stream fields
    localparam int CODE_W      = 8;
    localparam int TEMP_W      = 16;
    localparam int PULSE_W     = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int RESULT_W    = 28;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MS = 3'd4;

    localparam logic [7:0] RST_SETPOINT_LOW   = 8'd20;
    localparam logic [3:0] RST_BAND_WIDTH     = 4'd2;
    localparam logic [7:0] RST_PULSE_LIMIT    = 8'd90;
    localparam logic [7:0] RST_LONG_PULSE_MS  = 8'd50;
    localparam logic [7:0] RST_SHORT_PULSE_MS = 8'd25;

    // default averaging depth
    localparam int WINDOW_DEFAULT = 20;

    // code-to-temperature scaling, reduced by the common factor of five:
    // t = round((1610*S - 529*255*W) * 5120 / (50643*W))
    localparam longint MV_K      = 1610;
    localparam longint OFFSET_K  = 134895;
    localparam longint SCALE2_K  = 10240;
    localparam longint DEN_K     = 50643;
    localparam longint XPEAK_K   = 275655;

    typedef enum logic [1:0] {
        LED_NONE  = 2'd0,
        LED_AMBER = 2'd1,
        LED_GREEN = 2'd2,
        LED_RED   = 2'd3
    } led_t;

    typedef enum logic [1:0] {
        HEAT_OFF   = 2'd0,
        HEAT_ON    = 2'd1,
        HEAT_PULSE = 2'd2
    } heat_t;

    typedef struct packed {
        logic [7:0] setpoint_low;
        logic [3:0] band_width;
        logic [7:0] pulse_limit;
        logic [7:0] long_pulse_ms;
        logic [7:0] short_pulse_ms;
    } cfg_t;

    // one result, avg_temp in the low bits
    typedef struct packed {
        logic [PULSE_W-1:0]       pulse_ms;
        heat_t                    heater_mode;
        led_t                     led_state;
        logic signed [TEMP_W-1:0] avg_temp;
    } result_t;

endpackage

// ===== hdl/athc_cfg.sv =====
module athc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [athc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [athc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output athc_pkg::cfg_t                  cfg
);

    athc_pkg::cfg_t cfg_reg;

    // register writes by index, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint_low   <= athc_pkg::RST_SETPOINT_LOW;
            cfg_reg.band_width     <= athc_pkg::RST_BAND_WIDTH;
            cfg_reg.pulse_limit    <= athc_pkg::RST_PULSE_LIMIT;
            cfg_reg.long_pulse_ms  <= athc_pkg::RST_LONG_PULSE_MS;
            cfg_reg.short_pulse_ms <= athc_pkg::RST_SHORT_PULSE_MS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                athc_pkg::REG_SETPOINT_LOW:   cfg_reg.setpoint_low   <= cfg_wr_data;
                athc_pkg::REG_BAND_WIDTH:     cfg_reg.band_width     <= cfg_wr_data[3:0];
                athc_pkg::REG_PULSE_LIMIT:    cfg_reg.pulse_limit    <= cfg_wr_data;
                athc_pkg::REG_LONG_PULSE_MS:  cfg_reg.long_pulse_ms  <= cfg_wr_data;
                athc_pkg::REG_SHORT_PULSE_MS: cfg_reg.short_pulse_ms <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/athc_window.sv =====
module athc_window #(
    parameter int WINDOW = athc_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = $clog2((2 ** athc_pkg::CODE_W - 1) * WINDOW + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [athc_pkg::CODE_W-1:0] in_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SUM_W-1:0]            out_sum
);

    logic [athc_pkg::CODE_W-1:0] window_reg [WINDOW];
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            sum_next;
    logic                        valid_reg;
    logic                        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // oldest sample leaves the sum, new one enters
    assign sum_next = sum_reg - SUM_W'(window_reg[WINDOW-1]) + SUM_W'(in_code);

    // sample shift line, oldest at the tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (accept) begin
            window_reg[0] <= in_code;
            for (int i = 1; i < WINDOW; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_sum   = sum_reg;

endmodule

// ===== hdl/athc_conv.sv =====
module athc_conv #(
    parameter int WINDOW = athc_pkg::WINDOW_DEFAULT,
    parameter int SUM_W  = $clog2((2 ** athc_pkg::CODE_W - 1) * WINDOW + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SUM_W-1:0]                     in_sum,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [athc_pkg::TEMP_W-1:0]   out_temp
);

    localparam int     STAGES = 5;
    localparam longint OFF_K  = athc_pkg::OFFSET_K * WINDOW;
    localparam longint D_K    = athc_pkg::DEN_K * WINDOW;
    localparam longint E_K    = 2 * D_K;
    localparam longint X_MAX  = athc_pkg::XPEAK_K * WINDOW;
    localparam longint N_MAX  = athc_pkg::SCALE2_K * X_MAX + D_K;
    localparam int     P_W    = SUM_W + 11;
    localparam int     X_W    = $clog2(X_MAX + 1);
    localparam int     N_W    = $clog2(N_MAX + 1);
    localparam longint R_K    = (longint'(1) << N_W) / E_K;
    localparam int     R_W    = $clog2(R_K + 1);
    localparam int     PR_W   = N_W + R_W;
    localparam longint Q_MAX  = N_MAX / E_K;
    localparam int     Q_W    = $clog2(Q_MAX + 1);

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   en;
    logic [STAGES-1:0] v_in;

    logic                              neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg;
    logic [X_W-1:0]                    mag_a_reg;
    logic [N_W-1:0]                    n_b_reg, n_c_reg, n_d_reg;
    logic [Q_W-1:0]                    q0_c_reg, q0_d_reg;
    logic [N_W-1:0]                    m_d_reg;
    logic signed [athc_pkg::TEMP_W-1:0] temp_e_reg;

    logic [P_W-1:0]                    pos;
    logic                              neg_next;
    logic [X_W-1:0]                    mag_next;
    logic [N_W-1:0]                    n_next;
    logic [PR_W-1:0]                   prod;
    logic [N_W-1:0]                    m_next;
    logic [N_W-1:0]                    rem;
    logic [Q_W-1:0]                    q_fix;
    logic [athc_pkg::TEMP_W-1:0]       q_ext;
    logic signed [athc_pkg::TEMP_W-1:0] temp_next;

    // stall chain: a stage loads when it is empty or its successor loads
    always_comb begin
        en[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_in      = {v_reg[STAGES-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    // stage a: scaled sum minus offset, split into sign and magnitude
    always_comb begin
        pos      = P_W'(in_sum) * P_W'(athc_pkg::MV_K);
        neg_next = pos < P_W'(OFF_K);
        mag_next = neg_next ? X_W'(P_W'(OFF_K) - pos) : X_W'(pos - P_W'(OFF_K));
    end

    // stage b: rounding numerator
    assign n_next = N_W'(mag_a_reg) * N_W'(athc_pkg::SCALE2_K) + N_W'(D_K);

    // stage c: reciprocal estimate, low by at most one
    assign prod = PR_W'(n_b_reg) * PR_W'(R_K);

    // stage d: back-multiply the estimate
    assign m_next = N_W'(q0_c_reg) * N_W'(E_K);

    // stage e: one correction step and sign
    always_comb begin
        rem       = n_d_reg - m_d_reg;
        q_fix     = (rem >= N_W'(E_K)) ? q0_d_reg + Q_W'(1) : q0_d_reg;
        q_ext     = athc_pkg::TEMP_W'(q_fix);
        temp_next = neg_d_reg ? $signed(-q_ext) : $signed(q_ext);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_a_reg <= neg_next;
            mag_a_reg <= mag_next;
        end
        if (en[1]) begin
            neg_b_reg <= neg_a_reg;
            n_b_reg   <= n_next;
        end
        if (en[2]) begin
            neg_c_reg <= neg_b_reg;
            n_c_reg   <= n_b_reg;
            q0_c_reg  <= prod[N_W +: Q_W];
        end
        if (en[3]) begin
            neg_d_reg <= neg_c_reg;
            n_d_reg   <= n_c_reg;
            q0_d_reg  <= q0_c_reg;
            m_d_reg   <= m_next;
        end
        if (en[4]) begin
            temp_e_reg <= temp_next;
        end
    end

    assign out_temp = temp_e_reg;

endmodule

// ===== hdl/athc_band.sv =====
module athc_band (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [athc_pkg::TEMP_W-1:0] in_temp,
    input  athc_pkg::cfg_t                     cfg,
    output logic                               out_valid,
    input  logic                               out_ready,
    output athc_pkg::result_t                  out_result
);

    localparam int TH_W = 18;

    logic                    valid_reg;
    athc_pkg::result_t       result_reg;
    athc_pkg::result_t       result_next;
    athc_pkg::led_t          last_led_reg;
    logic                    last_heat_reg;
    logic                    last_heat_next;
    logic                    update;
    logic                    accept;
    logic signed [TH_W-1:0]  temp_ext;
    logic signed [TH_W-1:0]  lo;
    logic signed [TH_W-1:0]  bw;
    logic signed [TH_W-1:0]  hi;
    logic signed [TH_W-1:0]  warm;
    logic signed [TH_W-1:0]  plim;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // thresholds in Q10.8
    always_comb begin
        temp_ext = TH_W'(in_temp);
        lo       = $signed({2'b00, cfg.setpoint_low, 8'h00});
        bw       = $signed({6'b000000, cfg.band_width, 8'h00});
        hi       = lo + bw;
        warm     = lo - bw;
        plim     = $signed({2'b00, cfg.pulse_limit, 8'h00});
    end

    // band decision; exact hits keep the previous led state, and the heater stays on only after the cold band
    always_comb begin
        result_next.avg_temp    = in_temp;
        result_next.led_state   = last_led_reg;
        result_next.heater_mode = last_heat_reg ? athc_pkg::HEAT_ON : athc_pkg::HEAT_OFF;
        result_next.pulse_ms    = '0;
        update                  = 1'b0;
        last_heat_next          = 1'b0;
        if (temp_ext < warm) begin
            result_next.led_state   = athc_pkg::LED_AMBER;
            result_next.heater_mode = athc_pkg::HEAT_ON;
            update                  = 1'b1;
            last_heat_next          = 1'b1;
        end else if (warm < temp_ext && temp_ext < lo) begin
            result_next.led_state = athc_pkg::LED_AMBER;
            update                = 1'b1;
            if (temp_ext < plim) begin
                result_next.heater_mode = athc_pkg::HEAT_PULSE;
                result_next.pulse_ms    = cfg.long_pulse_ms;
            end else begin
                result_next.heater_mode = athc_pkg::HEAT_OFF;
            end
        end else if (lo < temp_ext && temp_ext < hi) begin
            result_next.led_state   = athc_pkg::LED_GREEN;
            result_next.heater_mode = athc_pkg::HEAT_PULSE;
            result_next.pulse_ms    = cfg.short_pulse_ms;
            update                  = 1'b1;
        end else if (hi < temp_ext) begin
            result_next.led_state   = athc_pkg::LED_RED;
            result_next.heater_mode = athc_pkg::HEAT_OFF;
            update                  = 1'b1;
        end
    end

    // output register and remembered state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            last_led_reg  <= athc_pkg::LED_NONE;
            last_heat_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept && update) begin
                last_led_reg  <= result_next.led_state;
                last_heat_reg <= last_heat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== hdl/averaged_thermostat_band_control.sv =====
// path: sum register, five divide-free conversion stages a to e, band output register
// throughput: one request per cycle while m_tready is high; the running-sum update and
//   the remembered led and heater state each loop through one register
// reset: aresetn is synchronous and active low; it zeroes the sample window and sum,
//   clears the remembered led and heater state, loads the register defaults
//   and empties the pipeline
module averaged_thermostat_band_control #(
    parameter int WINDOW = athc_pkg::WINDOW_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: adc_code [7:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [athc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: avg_temp [15:0], led_state [17:16], heater_mode [19:18],
    //          pulse_ms [27:20], zero [31:28]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [athc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [athc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [athc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int SUM_W = $clog2((2 ** athc_pkg::CODE_W - 1) * WINDOW + 1);

    athc_pkg::cfg_t                     cfg;
    athc_pkg::result_t                  res;
    logic                               sum_valid;
    logic                               sum_ready;
    logic [SUM_W-1:0]                   sum;
    logic                               temp_valid;
    logic                               temp_ready;
    logic signed [athc_pkg::TEMP_W-1:0] temp;

    // configuration registers
    athc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // sample window and running sum
    athc_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tdata[athc_pkg::CODE_W-1:0]),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    // sum to Q8.8 temperature
    athc_conv #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum),
        .out_valid (temp_valid),
        .out_ready (temp_ready),
        .out_temp  (temp)
    );

    // band compare and output register
    athc_band u_band (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (temp_valid),
        .in_ready   (temp_ready),
        .in_temp    (temp),
        .cfg        (cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {{athc_pkg::OUT_PAD_W{1'b0}}, res};

`ifndef SYNTHESIS
    // an empty output register means nothing can hold back the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

    // a red led always comes with the heater off
    a_red_heater_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.led_state == athc_pkg::LED_RED)
        |-> res.heater_mode == athc_pkg::HEAT_OFF)
        else $error("red led with heater not off");

    // a pulse length is only given with the pulse mode
    a_pulse_needs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.pulse_ms != '0) |-> res.heater_mode == athc_pkg::HEAT_PULSE)
        else $error("pulse length without pulse mode");
`endif

endmodule
